/* sv/ust_pkg.sv */
// Shared types, constants and helper functions for the UTF-8 source tokenizer.
// Used by ust_front, ust_engine and utf8_source_tokenizer; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ust_pkg;

    localparam int KEYWORD_COUNT_DEF = 9;
    localparam int COUNTER_BITS_DEF  = 16;
    localparam int LOOKAHEAD_DEPTH   = 3;
    localparam int QUEUE_DEPTH       = 4;
    localparam int MAX_KEYWORDS      = 16;

    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_LF     = 8'h0A;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_BANG   = 8'h21;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_DOT    = 8'h2E;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_UNDER  = 8'h5F;
    localparam logic [7:0] UTF_LEAD  = 8'hE0;
    localparam logic [7:0] UTF_HIGH  = 8'hA7;
    localparam logic [7:0] UTF_LOW   = 8'hA6;
    localparam logic [7:0] BDIG_ZERO = 8'hA6;
    localparam logic [7:0] BDIG_NINE = 8'hAF;

    localparam logic [4:0] T_IDENT   = 5'd0;
    localparam logic [4:0] T_INT     = 5'd10;
    localparam logic [4:0] T_FLOAT   = 5'd11;
    localparam logic [4:0] T_STR     = 5'd12;
    localparam logic [4:0] T_PLUS    = 5'd13;
    localparam logic [4:0] T_MINUS   = 5'd14;
    localparam logic [4:0] T_STAR    = 5'd15;
    localparam logic [4:0] T_SLASH   = 5'd16;
    localparam logic [4:0] T_LPAREN  = 5'd17;
    localparam logic [4:0] T_RPAREN  = 5'd18;
    localparam logic [4:0] T_SEMI    = 5'd19;
    localparam logic [4:0] T_ASSIGN  = 5'd20;
    localparam logic [4:0] T_EQ      = 5'd21;
    localparam logic [4:0] T_NE      = 5'd22;
    localparam logic [4:0] T_LT      = 5'd23;
    localparam logic [4:0] T_LE      = 5'd24;
    localparam logic [4:0] T_GT      = 5'd25;
    localparam logic [4:0] T_GE      = 5'd26;
    localparam logic [4:0] T_UNKNOWN = 5'd27;
    localparam logic [4:0] T_END     = 5'd28;

    localparam logic [1:0] ERR_NONE    = 2'd0;
    localparam logic [1:0] ERR_UNKNOWN = 2'd1;
    localparam logic [1:0] ERR_BANG    = 2'd2;
    localparam logic [1:0] ERR_UNTERM  = 2'd3;

    // Keyword code points as offsets from U+0980, and lengths in characters.
    localparam logic [2:0] KW_CHARS [MAX_KEYWORDS] =
        '{3'd3, 3'd6, 3'd5, 3'd3, 3'd5, 3'd6, 3'd5, 3'd4, 3'd3,
          3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0, 3'd0};
    localparam logic [5:0] KW_CP [MAX_KEYWORDS][6] = '{
        '{6'h27, 6'h30, 6'h3F, 6'h00, 6'h00, 6'h00},
        '{6'h38, 6'h02, 6'h16, 6'h0D, 6'h2F, 6'h3E},
        '{6'h26, 6'h36, 6'h2E, 6'h3F, 6'h15, 6'h00},
        '{6'h2F, 6'h26, 6'h3F, 6'h00, 6'h00, 6'h00},
        '{6'h28, 6'h3E, 6'h39, 6'h32, 6'h07, 6'h00},
        '{6'h2F, 6'h24, 6'h15, 6'h0D, 6'h37, 6'h23},
        '{6'h26, 6'h07, 6'h16, 6'h3E, 6'h13, 6'h00},
        '{6'h36, 6'h01, 6'h30, 6'h01, 6'h00, 6'h00},
        '{6'h36, 6'h07, 6'h37, 6'h00, 6'h00, 6'h00},
        '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
        '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
        '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
        '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
        '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
        '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00},
        '{6'h00, 6'h00, 6'h00, 6'h00, 6'h00, 6'h00}};
    // Offsets of 0x40 and above sit in the A7 block; the table keeps the low six bits.
    localparam logic KW_HIGH [MAX_KEYWORDS][6] = '{
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0},
        '{1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
        '{1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0}};

    typedef enum logic [3:0] {
        MD_IDLE    = 4'd0,
        MD_IDENT   = 4'd1,
        MD_NUM     = 4'd2,
        MD_NUMFRAC = 4'd3,
        MD_BNUM    = 4'd4,
        MD_BFRAC   = 4'd5,
        MD_STR     = 4'd6,
        MD_COMMENT = 4'd7
    } scan_mode_t;

    typedef enum logic [2:0] {
        ES_READY   = 3'd0,
        ES_RUN     = 3'd1,
        ES_EOF_FIN = 3'd2,
        ES_EOF_END = 3'd3,
        ES_FLUSH   = 3'd4
    } eng_state_t;

    typedef struct packed {
        logic digit;
        logic wstart;
        logic blank;
    } cls_t;

    typedef struct packed {
        logic [7:0] data;
        cls_t       cls;
    } ent_t;

    typedef struct packed {
        ent_t ent;
        logic eof;
    } qitem_t;

    typedef struct packed {
        logic [4:0]  token_type;
        logic [1:0]  error_code;
        logic [15:0] start_line;
        logic [15:0] start_col;
        logic [15:0] byte_length;
        logic [31:0] int_value;
    } res_t;

    function automatic cls_t classify(input logic [7:0] b);
        cls_t c;
        c.digit  = (b >= CH_ZERO) && (b <= CH_NINE);
        c.wstart = ((b >= 8'h41) && (b <= 8'h5A)) || ((b >= 8'h61) && (b <= 8'h7A)) ||
                   (b == CH_UNDER) || b[7];
        c.blank  = (b == CH_SPACE) || (b == CH_TAB) || (b == CH_CR) || (b == CH_LF);
        return c;
    endfunction

    function automatic logic [4:0] kw_len3(input logic [3:0] k);
        logic [4:0] l;
        l = {2'b00, KW_CHARS[k]};
        return (l << 1) + l;
    endfunction

    function automatic logic [7:0] kw_byte(input logic [3:0] k, input logic [4:0] pos);
        logic [2:0] ch;
        logic [4:0] ph;
        logic [7:0] r;
        ch = 3'd0;
        ph = pos;
        for (int j = 1; j < 6; j++) begin
            if (pos >= 5'(3 * j)) begin
                ch = 3'(j);
                ph = pos - 5'(3 * j);
            end
        end
        case (ph)
            5'd0:    r = UTF_LEAD;
            5'd1:    r = KW_HIGH[k][ch] ? UTF_HIGH : UTF_LOW;
            default: r = {2'b10, KW_CP[k][ch]};
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

/* sv/utf8_source_tokenizer.sv */
// Top level of the UTF-8 source tokenizer: byte queue front and scanning back end.
// Depends on ust_pkg, ust_front and ust_engine.
//
// Usage: source bytes enter on the input channel (in_valid, in_stall, in_byte,
// end_of_input), one byte per item. Tokens leave on the output channel
// (out_valid, out_stall and the token fields), one token per item, with last
// set on the final token caused by an input byte. An item is taken when valid
// is high and stall is low at a rising clock edge.
// Bytes pass through a four-entry queue into the scanner, so a stalled output
// does not stop the input until the queue fills. The scanner handles one byte
// per cycle while the output does not stall; each token that ends on a
// following byte, and each extra token caused by one byte, holds the next
// byte back. A byte marked end_of_input is followed by the flush of the open
// token and the end token, after which the block is back in its reset state.
// While out_stall is high with a token waiting, the result register holds and
// the scanner waits. Reset clears the queue, the counters (line and column to
// 1) and any partial token.
`timescale 1ns / 1ps
`default_nettype none

module utf8_source_tokenizer #(
    parameter int KEYWORD_COUNT = ust_pkg::KEYWORD_COUNT_DEF,
    parameter int COUNTER_BITS  = ust_pkg::COUNTER_BITS_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic [7:0]  in_byte,
    input  wire logic        end_of_input,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic [4:0]       token_type,
    output logic [1:0]       error_code,
    output logic [15:0]      start_line,
    output logic [15:0]      start_col,
    output logic [15:0]      byte_length,
    output logic [31:0]      int_value,
    output logic             last
);

    logic            q_valid;
    logic            q_pop;
    ust_pkg::qitem_t q_head;
    ust_pkg::res_t   res;

    ust_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .in_byte      (in_byte),
        .end_of_input (end_of_input),
        .q_valid      (q_valid),
        .q_head       (q_head),
        .q_pop        (q_pop)
    );

    ust_engine #(
        .KEYWORD_COUNT (KEYWORD_COUNT),
        .COUNTER_BITS  (COUNTER_BITS)
    ) u_engine (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_head    (q_head),
        .q_pop     (q_pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (res),
        .out_last  (last)
    );

    assign token_type  = res.token_type;
    assign error_code  = res.error_code;
    assign start_line  = res.start_line;
    assign start_col   = res.start_col;
    assign byte_length = res.byte_length;
    assign int_value   = res.int_value;

endmodule

`default_nettype wire

/* sv/ust_front.sv */
// Front part of the tokenizer: accepts source bytes, classifies them and queues them.
// Depends on ust_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ust_front (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_stall,
    input  wire logic [7:0]      in_byte,
    input  wire logic            end_of_input,
    output logic                 q_valid,
    output ust_pkg::qitem_t      q_head,
    input  wire logic            q_pop
);

    localparam int PW = $clog2(ust_pkg::QUEUE_DEPTH);

    ust_pkg::qitem_t q_reg [ust_pkg::QUEUE_DEPTH];
    logic [PW-1:0]   wptr_reg, wptr_next;
    logic [PW-1:0]   rptr_reg, rptr_next;
    logic [PW:0]     cnt_reg, cnt_next;
    logic            push;
    ust_pkg::qitem_t item;

    assign in_stall = (cnt_reg == (PW+1)'(ust_pkg::QUEUE_DEPTH));
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != '0);
    assign q_head   = q_reg[rptr_reg];

    always_comb
    begin
        item.ent.data = in_byte;
        item.ent.cls  = ust_pkg::classify(in_byte);
        item.eof      = end_of_input;
        wptr_next     = push ? wptr_reg + 1'b1 : wptr_reg;
        rptr_next     = q_pop ? rptr_reg + 1'b1 : rptr_reg;
        cnt_next      = cnt_reg + (PW+1)'(push) - (PW+1)'(q_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg  <= '0;
        end
        else
        begin
            wptr_reg <= wptr_next;
            rptr_reg <= rptr_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wptr_reg] <= item;
        end
    end

endmodule

`default_nettype wire

/* sv/ust_engine.sv */
// Back part of the tokenizer: scans queued bytes, builds tokens and drives the result register.
// Depends on ust_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ust_engine #(
    parameter int KEYWORD_COUNT = ust_pkg::KEYWORD_COUNT_DEF,
    parameter int COUNTER_BITS  = ust_pkg::COUNTER_BITS_DEF
) (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_valid,
    input  ust_pkg::qitem_t       q_head,
    output logic                  q_pop,
    output logic                  out_valid,
    input  wire logic             out_stall,
    output ust_pkg::res_t         out_res,
    output logic                  out_last
);

    localparam int CB = COUNTER_BITS;
    localparam int KC = KEYWORD_COUNT;
    localparam logic [CB-1:0] CNT_ONE = CB'(1);

    function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] a, input logic [1:0] b);
        logic [CB:0] s;
        s = {1'b0, a} + (CB+1)'(b);
        return s[CB] ? '1 : s[CB-1:0];
    endfunction

    function automatic logic [15:0] to16(input logic [CB-1:0] a);
        logic [31:0] w;
        w = 32'(a);
        return w[15:0];
    endfunction

    ust_pkg::eng_state_t state_reg, state_next;
    ust_pkg::scan_mode_t mode_reg, mode_next;
    logic [CB-1:0] line_reg, line_next, col_reg, col_next;
    logic [CB-1:0] tsl_reg, tsl_next, tsc_reg, tsc_next, tlen_reg, tlen_next;
    logic [31:0]   acc_reg, acc_next;
    logic [KC-1:0] cand_reg, cand_next;
    logic [4:0]    kpos_reg, kpos_next;
    logic [1:0]    fill_reg, fill_next;
    logic [2:0]    wn_reg, wn_next;
    logic          weof_reg, weof_next;
    logic          pend_v_reg, pend_v_next;
    logic          out_v_reg, out_v_next;
    logic          last_reg, last_next;
    ust_pkg::ent_t la_reg [ust_pkg::LOOKAHEAD_DEPTH];
    ust_pkg::ent_t la_next [ust_pkg::LOOKAHEAD_DEPTH];
    ust_pkg::ent_t wb_reg [4];
    ust_pkg::ent_t wb_next [4];
    ust_pkg::res_t pend_reg, pend_next, res_reg, res_next;

    ust_pkg::ent_t v [4];
    ust_pkg::ent_t sh [4];
    logic [2:0]    n;
    logic          veof, vvalid;
    logic [7:0]    c, b1, b2, b3;
    logic          pres1, pres2, pres3, q1ok;
    logic          ben0_no, ben0_wait, ben1_no, ben1_wait;

    logic [1:0]    it_cons;
    logic          it_wait, it_emit, it_begin, it_dig_en, it_take, it_ident, it_fin;
    logic [3:0]    it_dig;
    ust_pkg::res_t it_res, fin_res, op_res;
    ust_pkg::scan_mode_t it_mode;
    logic          fin_emit;
    logic [4:0]    kw_type;
    logic [2:0]    rem;

    logic [CB-1:0] len_base, upd_len, upd_line, upd_col, upd_tsl, upd_tsc;
    logic [31:0]   acc_base, upd_acc;
    logic [35:0]   mul;
    logic [KC-1:0] cand_base, upd_cand;
    logic [4:0]    kpos_base, upd_kpos;

    logic          go, emit_any, end_item, push, push_last;
    ust_pkg::res_t emit_r, push_res;

    always_comb
    begin
        if (state_reg == ust_pkg::ES_RUN)
        begin
            for (int k = 0; k < 4; k++)
            begin
                v[k] = wb_reg[k];
            end
            n      = wn_reg;
            veof   = weof_reg;
            vvalid = 1'b1;
        end
        else
        begin
            for (int k = 0; k < 3; k++)
            begin
                v[k] = (2'(k) < fill_reg) ? la_reg[k] : q_head.ent;
            end
            v[3]   = q_head.ent;
            n      = {1'b0, fill_reg} + 3'd1;
            veof   = q_head.eof;
            vvalid = (state_reg == ust_pkg::ES_READY) && q_valid;
        end
    end

    assign c     = v[0].data;
    assign b1    = v[1].data;
    assign b2    = v[2].data;
    assign b3    = v[3].data;
    assign pres1 = (n > 3'd1);
    assign pres2 = (n > 3'd2);
    assign pres3 = (n > 3'd3);
    assign q1ok  = pres1 || veof;

    assign ben0_no   = (c != ust_pkg::UTF_LEAD) || (pres1 && (b1 != ust_pkg::UTF_HIGH)) ||
                       (pres2 && !((b2 >= ust_pkg::BDIG_ZERO) && (b2 <= ust_pkg::BDIG_NINE))) ||
                       (!pres2 && veof);
    assign ben0_wait = !ben0_no && !pres2;
    assign ben1_no   = (pres2 && (b2 != ust_pkg::UTF_HIGH)) ||
                       (pres3 && !((b3 >= ust_pkg::BDIG_ZERO) && (b3 <= ust_pkg::BDIG_NINE))) ||
                       (!pres3 && veof);
    assign ben1_wait = !ben1_no && !pres3;

    always_comb
    begin
        kw_type = ust_pkg::T_IDENT;
        for (int k = 0; k < KC; k++)
        begin
            if (cand_reg[k] && (ust_pkg::KW_CHARS[k] != 3'd0) &&
                (kpos_reg == ust_pkg::kw_len3(4'(k))))
            begin
                kw_type = 5'(k + 1);
            end
        end
        fin_res             = '0;
        fin_res.start_line  = to16(tsl_reg);
        fin_res.start_col   = to16(tsc_reg);
        fin_res.byte_length = to16(tlen_reg);
        fin_emit            = 1'b1;
        unique case (mode_reg)
            ust_pkg::MD_IDENT:
            begin
                fin_res.token_type = kw_type;
            end
            ust_pkg::MD_NUM, ust_pkg::MD_BNUM:
            begin
                fin_res.token_type = ust_pkg::T_INT;
                fin_res.int_value  = acc_reg;
            end
            ust_pkg::MD_NUMFRAC, ust_pkg::MD_BFRAC:
            begin
                fin_res.token_type = ust_pkg::T_FLOAT;
                fin_res.int_value  = acc_reg;
            end
            ust_pkg::MD_STR:
            begin
                fin_res.token_type = ust_pkg::T_UNKNOWN;
                fin_res.error_code = ust_pkg::ERR_UNTERM;
            end
            default:
            begin
                fin_emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        op_res            = '0;
        op_res.start_line = to16(line_reg);
        op_res.start_col  = to16(col_reg);
        it_cons   = 2'd0;
        it_wait   = 1'b0;
        it_emit   = 1'b0;
        it_res    = op_res;
        it_mode   = mode_reg;
        it_begin  = 1'b0;
        it_dig_en = 1'b0;
        it_dig    = 4'd0;
        it_take   = 1'b0;
        it_ident  = 1'b0;
        it_fin    = 1'b0;
        unique case (mode_reg)
            ust_pkg::MD_IDLE:
            begin
                it_res.byte_length = 16'd1;
                case (c)
                    ust_pkg::CH_SPACE, ust_pkg::CH_TAB, ust_pkg::CH_CR, ust_pkg::CH_LF:
                    begin
                        it_cons = 2'd1;
                    end
                    ust_pkg::CH_SLASH:
                    begin
                        if (!q1ok)
                        begin
                            it_wait = 1'b1;
                        end
                        else if (pres1 && (b1 == ust_pkg::CH_SLASH))
                        begin
                            it_cons = 2'd2;
                            it_mode = ust_pkg::MD_COMMENT;
                        end
                        else
                        begin
                            it_emit           = 1'b1;
                            it_res.token_type = ust_pkg::T_SLASH;
                            it_cons           = 2'd1;
                        end
                    end
                    ust_pkg::CH_PLUS, ust_pkg::CH_MINUS, ust_pkg::CH_STAR,
                    ust_pkg::CH_LPAREN, ust_pkg::CH_RPAREN, ust_pkg::CH_SEMI:
                    begin
                        it_emit = 1'b1;
                        it_cons = 2'd1;
                        case (c)
                            ust_pkg::CH_PLUS:   it_res.token_type = ust_pkg::T_PLUS;
                            ust_pkg::CH_MINUS:  it_res.token_type = ust_pkg::T_MINUS;
                            ust_pkg::CH_STAR:   it_res.token_type = ust_pkg::T_STAR;
                            ust_pkg::CH_LPAREN: it_res.token_type = ust_pkg::T_LPAREN;
                            ust_pkg::CH_RPAREN: it_res.token_type = ust_pkg::T_RPAREN;
                            default:            it_res.token_type = ust_pkg::T_SEMI;
                        endcase
                    end
                    ust_pkg::CH_EQ, ust_pkg::CH_BANG, ust_pkg::CH_LT, ust_pkg::CH_GT:
                    begin
                        if (!q1ok)
                        begin
                            it_wait = 1'b1;
                        end
                        else if (pres1 && (b1 == ust_pkg::CH_EQ))
                        begin
                            it_emit            = 1'b1;
                            it_cons            = 2'd2;
                            it_res.byte_length = 16'd2;
                            case (c)
                                ust_pkg::CH_EQ:   it_res.token_type = ust_pkg::T_EQ;
                                ust_pkg::CH_BANG: it_res.token_type = ust_pkg::T_NE;
                                ust_pkg::CH_LT:   it_res.token_type = ust_pkg::T_LE;
                                default:          it_res.token_type = ust_pkg::T_GE;
                            endcase
                        end
                        else
                        begin
                            it_emit = 1'b1;
                            it_cons = 2'd1;
                            case (c)
                                ust_pkg::CH_EQ:   it_res.token_type = ust_pkg::T_ASSIGN;
                                ust_pkg::CH_LT:   it_res.token_type = ust_pkg::T_LT;
                                ust_pkg::CH_GT:   it_res.token_type = ust_pkg::T_GT;
                                default:
                                begin
                                    it_res.token_type = ust_pkg::T_UNKNOWN;
                                    it_res.error_code = ust_pkg::ERR_BANG;
                                end
                            endcase
                        end
                    end
                    ust_pkg::CH_QUOTE:
                    begin
                        it_begin = 1'b1;
                        it_take  = 1'b1;
                        it_cons  = 2'd1;
                        it_mode  = ust_pkg::MD_STR;
                    end
                    default:
                    begin
                        if (v[0].cls.digit)
                        begin
                            it_begin  = 1'b1;
                            it_dig_en = 1'b1;
                            it_dig    = 4'(c - ust_pkg::CH_ZERO);
                            it_take   = 1'b1;
                            it_cons   = 2'd1;
                            it_mode   = ust_pkg::MD_NUM;
                        end
                        else if ((c == ust_pkg::UTF_LEAD) && ben0_wait)
                        begin
                            it_wait = 1'b1;
                        end
                        else if ((c == ust_pkg::UTF_LEAD) && !ben0_no)
                        begin
                            it_begin  = 1'b1;
                            it_dig_en = 1'b1;
                            it_dig    = 4'(b2 - ust_pkg::BDIG_ZERO);
                            it_take   = 1'b1;
                            it_cons   = 2'd3;
                            it_mode   = ust_pkg::MD_BNUM;
                        end
                        else if (v[0].cls.wstart)
                        begin
                            it_begin = 1'b1;
                            it_ident = 1'b1;
                            it_take  = 1'b1;
                            it_cons  = 2'd1;
                            it_mode  = ust_pkg::MD_IDENT;
                        end
                        else
                        begin
                            it_emit           = 1'b1;
                            it_res.token_type = ust_pkg::T_UNKNOWN;
                            it_res.error_code = ust_pkg::ERR_UNKNOWN;
                            it_cons           = 2'd1;
                        end
                    end
                endcase
            end
            ust_pkg::MD_IDENT:
            begin
                if (v[0].cls.wstart || v[0].cls.digit)
                begin
                    it_ident = 1'b1;
                    it_take  = 1'b1;
                    it_cons  = 2'd1;
                end
                else
                begin
                    it_fin = 1'b1;
                end
            end
            ust_pkg::MD_NUM:
            begin
                if (v[0].cls.digit)
                begin
                    it_dig_en = 1'b1;
                    it_dig    = 4'(c - ust_pkg::CH_ZERO);
                    it_take   = 1'b1;
                    it_cons   = 2'd1;
                end
                else if (c == ust_pkg::CH_DOT)
                begin
                    if (!q1ok)
                    begin
                        it_wait = 1'b1;
                    end
                    else if (pres1 && v[1].cls.digit)
                    begin
                        it_take = 1'b1;
                        it_cons = 2'd1;
                        it_mode = ust_pkg::MD_NUMFRAC;
                    end
                    else
                    begin
                        it_fin = 1'b1;
                    end
                end
                else
                begin
                    it_fin = 1'b1;
                end
            end
            ust_pkg::MD_NUMFRAC:
            begin
                if (v[0].cls.digit)
                begin
                    it_take = 1'b1;
                    it_cons = 2'd1;
                end
                else
                begin
                    it_fin = 1'b1;
                end
            end
            ust_pkg::MD_BNUM:
            begin
                if (c == ust_pkg::UTF_LEAD)
                begin
                    if (ben0_wait)
                    begin
                        it_wait = 1'b1;
                    end
                    else if (!ben0_no)
                    begin
                        it_dig_en = 1'b1;
                        it_dig    = 4'(b2 - ust_pkg::BDIG_ZERO);
                        it_take   = 1'b1;
                        it_cons   = 2'd3;
                    end
                    else
                    begin
                        it_fin = 1'b1;
                    end
                end
                else if (c == ust_pkg::CH_DOT)
                begin
                    if (!q1ok)
                    begin
                        it_wait = 1'b1;
                    end
                    else if (pres1 && v[1].cls.digit)
                    begin
                        it_take = 1'b1;
                        it_cons = 2'd1;
                        it_mode = ust_pkg::MD_BFRAC;
                    end
                    else if (pres1 && (b1 == ust_pkg::UTF_LEAD) && ben1_wait)
                    begin
                        it_wait = 1'b1;
                    end
                    else if (pres1 && (b1 == ust_pkg::UTF_LEAD) && !ben1_no)
                    begin
                        it_take = 1'b1;
                        it_cons = 2'd1;
                        it_mode = ust_pkg::MD_BFRAC;
                    end
                    else
                    begin
                        it_fin = 1'b1;
                    end
                end
                else
                begin
                    it_fin = 1'b1;
                end
            end
            ust_pkg::MD_BFRAC:
            begin
                if (c == ust_pkg::UTF_LEAD)
                begin
                    if (ben0_wait)
                    begin
                        it_wait = 1'b1;
                    end
                    else if (!ben0_no)
                    begin
                        it_take = 1'b1;
                        it_cons = 2'd3;
                    end
                    else
                    begin
                        it_fin = 1'b1;
                    end
                end
                else if (v[0].cls.digit)
                begin
                    it_take = 1'b1;
                    it_cons = 2'd1;
                end
                else
                begin
                    it_fin = 1'b1;
                end
            end
            ust_pkg::MD_STR:
            begin
                if (c == ust_pkg::CH_QUOTE)
                begin
                    it_take            = 1'b1;
                    it_cons            = 2'd1;
                    it_emit            = 1'b1;
                    it_res.token_type  = ust_pkg::T_STR;
                    it_res.start_line  = to16(tsl_reg);
                    it_res.start_col   = to16(tsc_reg);
                    it_res.byte_length = to16(sat_add(tlen_reg, 2'd1));
                    it_mode            = ust_pkg::MD_IDLE;
                end
                else if (c == ust_pkg::CH_LF)
                begin
                    it_fin = 1'b1;
                end
                else
                begin
                    it_take = 1'b1;
                    it_cons = 2'd1;
                end
            end
            ust_pkg::MD_COMMENT:
            begin
                if (c == ust_pkg::CH_LF)
                begin
                    it_mode = ust_pkg::MD_IDLE;
                end
                else
                begin
                    it_cons = 2'd1;
                end
            end
            default:
            begin
                it_mode = ust_pkg::MD_IDLE;
            end
        endcase
        if (it_fin)
        begin
            it_emit = fin_emit;
            it_res  = fin_res;
            it_mode = ust_pkg::MD_IDLE;
        end
    end

    always_comb
    begin
        upd_tsl   = it_begin ? line_reg : tsl_reg;
        upd_tsc   = it_begin ? col_reg : tsc_reg;
        len_base  = it_begin ? '0 : tlen_reg;
        acc_base  = it_begin ? 32'd0 : acc_reg;
        cand_base = it_begin ? '1 : cand_reg;
        kpos_base = it_begin ? 5'd0 : kpos_reg;
        upd_len   = it_take ? sat_add(len_base, it_cons) : len_base;
        mul       = ({4'd0, acc_base} << 3) + ({4'd0, acc_base} << 1) + 36'(it_dig);
        upd_acc   = it_dig_en ? ((mul[35:32] != 4'd0) ? 32'hFFFF_FFFF : mul[31:0]) : acc_base;
        upd_cand  = cand_base;
        upd_kpos  = kpos_base;
        if (it_ident)
        begin
            for (int k = 0; k < KC; k++)
            begin
                if ((kpos_base >= ust_pkg::kw_len3(4'(k))) ||
                    (ust_pkg::kw_byte(4'(k), kpos_base) != c))
                begin
                    upd_cand[k] = 1'b0;
                end
            end
            upd_kpos = (kpos_base < 5'd31) ? kpos_base + 5'd1 : kpos_base;
        end
        if ((it_cons == 2'd1) && (c == ust_pkg::CH_LF))
        begin
            upd_line = sat_add(line_reg, 2'd1);
            upd_col  = CNT_ONE;
        end
        else
        begin
            upd_line = line_reg;
            upd_col  = sat_add(col_reg, it_cons);
        end
        rem = n - {1'b0, it_cons};
        for (int k = 0; k < 4; k++)
        begin
            case (it_cons)
                2'd0:    sh[k] = v[k];
                2'd1:    sh[k] = (k < 3) ? v[(k + 1) % 4] : v[3];
                2'd2:    sh[k] = (k < 2) ? v[(k + 2) % 4] : v[3];
                default: sh[k] = (k < 1) ? v[3] : v[3];
            endcase
        end
    end

    assign go = !out_v_reg || !out_stall;

    always_comb
    begin
        state_next  = state_reg;
        mode_next   = mode_reg;
        line_next   = line_reg;
        col_next    = col_reg;
        tsl_next    = tsl_reg;
        tsc_next    = tsc_reg;
        tlen_next   = tlen_reg;
        acc_next    = acc_reg;
        cand_next   = cand_reg;
        kpos_next   = kpos_reg;
        fill_next   = fill_reg;
        wn_next     = wn_reg;
        weof_next   = weof_reg;
        pend_v_next = pend_v_reg;
        pend_next   = pend_reg;
        for (int k = 0; k < ust_pkg::LOOKAHEAD_DEPTH; k++)
        begin
            la_next[k] = la_reg[k];
        end
        for (int k = 0; k < 4; k++)
        begin
            wb_next[k] = wb_reg[k];
        end
        q_pop     = 1'b0;
        emit_any  = 1'b0;
        emit_r    = it_res;
        end_item  = 1'b0;
        push      = 1'b0;
        push_res  = pend_reg;
        push_last = 1'b0;
        unique case (state_reg)
            ust_pkg::ES_READY, ust_pkg::ES_RUN:
            begin
                if (vvalid && go)
                begin
                    q_pop     = (state_reg == ust_pkg::ES_READY);
                    mode_next = it_mode;
                    line_next = upd_line;
                    col_next  = upd_col;
                    tsl_next  = upd_tsl;
                    tsc_next  = upd_tsc;
                    tlen_next = upd_len;
                    acc_next  = upd_acc;
                    cand_next = upd_cand;
                    kpos_next = upd_kpos;
                    emit_any  = it_emit;
                    emit_r    = it_res;
                    if (!it_wait && (rem != 3'd0))
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            wb_next[k] = sh[k];
                        end
                        wn_next    = rem;
                        weof_next  = veof;
                        state_next = ust_pkg::ES_RUN;
                    end
                    else
                    begin
                        fill_next = it_wait ? rem[1:0] : 2'd0;
                        for (int k = 0; k < ust_pkg::LOOKAHEAD_DEPTH; k++)
                        begin
                            la_next[k] = sh[k];
                        end
                        if (veof)
                        begin
                            state_next = ust_pkg::ES_EOF_FIN;
                        end
                        else
                        begin
                            end_item   = 1'b1;
                            state_next = ust_pkg::ES_READY;
                        end
                    end
                end
            end
            ust_pkg::ES_EOF_FIN:
            begin
                if (go)
                begin
                    emit_any   = fin_emit;
                    emit_r     = fin_res;
                    mode_next  = ust_pkg::MD_IDLE;
                    state_next = ust_pkg::ES_EOF_END;
                end
            end
            ust_pkg::ES_EOF_END:
            begin
                if (go)
                begin
                    emit_any          = 1'b1;
                    emit_r            = '0;
                    emit_r.token_type = ust_pkg::T_END;
                    emit_r.start_line = to16(line_reg);
                    emit_r.start_col  = to16(col_reg);
                    end_item          = 1'b1;
                    state_next        = ust_pkg::ES_READY;
                    mode_next         = ust_pkg::MD_IDLE;
                    line_next         = CNT_ONE;
                    col_next          = CNT_ONE;
                    tsl_next          = CNT_ONE;
                    tsc_next          = CNT_ONE;
                    tlen_next         = '0;
                    acc_next          = 32'd0;
                    cand_next         = '1;
                    kpos_next         = 5'd0;
                    fill_next         = 2'd0;
                end
            end
            ust_pkg::ES_FLUSH:
            begin
                if (go)
                begin
                    push        = 1'b1;
                    push_res    = pend_reg;
                    push_last   = 1'b1;
                    pend_v_next = 1'b0;
                    state_next  = ust_pkg::ES_READY;
                end
            end
            default:
            begin
                state_next = ust_pkg::ES_READY;
            end
        endcase
        if (emit_any && end_item)
        begin
            push = 1'b1;
            if (pend_v_reg)
            begin
                push_res    = pend_reg;
                push_last   = 1'b0;
                pend_next   = emit_r;
                pend_v_next = 1'b1;
                state_next  = ust_pkg::ES_FLUSH;
            end
            else
            begin
                push_res  = emit_r;
                push_last = 1'b1;
            end
        end
        else if (emit_any)
        begin
            push        = pend_v_reg;
            push_res    = pend_reg;
            push_last   = 1'b0;
            pend_next   = emit_r;
            pend_v_next = 1'b1;
        end
        else if (end_item)
        begin
            push        = pend_v_reg;
            push_res    = pend_reg;
            push_last   = 1'b1;
            pend_v_next = 1'b0;
        end
        out_v_next = push ? 1'b1 : (out_v_reg && out_stall);
        res_next   = push ? push_res : res_reg;
        last_next  = push ? push_last : last_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ust_pkg::ES_READY;
            mode_reg   <= ust_pkg::MD_IDLE;
            line_reg   <= CNT_ONE;
            col_reg    <= CNT_ONE;
            tsl_reg    <= CNT_ONE;
            tsc_reg    <= CNT_ONE;
            tlen_reg   <= '0;
            acc_reg    <= 32'd0;
            cand_reg   <= '1;
            kpos_reg   <= 5'd0;
            fill_reg   <= 2'd0;
            wn_reg     <= 3'd0;
            weof_reg   <= 1'b0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            mode_reg   <= mode_next;
            line_reg   <= line_next;
            col_reg    <= col_next;
            tsl_reg    <= tsl_next;
            tsc_reg    <= tsc_next;
            tlen_reg   <= tlen_next;
            acc_reg    <= acc_next;
            cand_reg   <= cand_next;
            kpos_reg   <= kpos_next;
            fill_reg   <= fill_next;
            wn_reg     <= wn_next;
            weof_reg   <= weof_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ust_pkg::LOOKAHEAD_DEPTH; k++)
        begin
            la_reg[k] <= la_next[k];
        end
        for (int k = 0; k < 4; k++)
        begin
            wb_reg[k] <= wb_next[k];
        end
        pend_reg <= pend_next;
        res_reg  <= res_next;
        last_reg <= last_next;
    end

    assign out_valid = out_v_reg;
    assign out_res   = res_reg;
    assign out_last  = last_reg;

endmodule

`default_nettype wire

/* tb/utf8_source_tokenizer_tb.sv */
// Self-checking testbench for utf8_source_tokenizer: a directed byte table, then random
// source text, checked against tokens given in the table or a behavioral tokenizer in this file.
// Depends on ust_pkg and the utf8_source_tokenizer RTL.
`timescale 1ns / 1ps

module utf8_source_tokenizer_tb;

    import ust_pkg::*;

    typedef struct packed {
        logic [4:0]  tt;
        logic [1:0]  ec;
        logic [15:0] sl;
        logic [15:0] sc;
        logic [15:0] bl;
        logic [31:0] iv;
        logic        lst;
    } tok_t;

    typedef struct {
        logic [7:0] b;
        logic       eof;
        bit         typed;
        tok_t       want;
    } stim_row_t;

    localparam int unsigned CNT_MAX = 65535;
    localparam int WATCHDOG = 3000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  in_byte = 8'h00;
    logic        end_of_input = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [4:0]  token_type;
    logic [1:0]  error_code;
    logic [15:0] start_line;
    logic [15:0] start_col;
    logic [15:0] byte_length;
    logic [31:0] int_value;
    logic        last;

    utf8_source_tokenizer dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_byte(in_byte),
        .end_of_input(end_of_input),
        .out_valid(out_valid), .out_stall(out_stall),
        .token_type(token_type), .error_code(error_code), .start_line(start_line),
        .start_col(start_col), .byte_length(byte_length), .int_value(int_value),
        .last(last)
    );

    always #10 clk = ~clk;

    // Keywords as code point offsets from U+0980 and lengths in characters.
    int unsigned kw_len [9] = '{3, 6, 5, 3, 5, 6, 5, 4, 3};
    logic [7:0] kw_cp [9][6] = '{
        '{8'h27, 8'h30, 8'h3F, 8'h00, 8'h00, 8'h00},
        '{8'h38, 8'h02, 8'h16, 8'h4D, 8'h2F, 8'h3E},
        '{8'h26, 8'h36, 8'h2E, 8'h3F, 8'h15, 8'h00},
        '{8'h2F, 8'h26, 8'h3F, 8'h00, 8'h00, 8'h00},
        '{8'h28, 8'h3E, 8'h39, 8'h32, 8'h47, 8'h00},
        '{8'h2F, 8'h24, 8'h15, 8'h4D, 8'h37, 8'h23},
        '{8'h26, 8'h47, 8'h16, 8'h3E, 8'h13, 8'h00},
        '{8'h36, 8'h41, 8'h30, 8'h41, 8'h00, 8'h00},
        '{8'h36, 8'h47, 8'h37, 8'h00, 8'h00, 8'h00}};

    int unsigned ln, cl, tsl, tsc, tlen, vacc, kpos;
    logic [8:0]  kwc;
    scan_mode_t  md;
    logic [7:0]  la [3];
    int          la_n;
    logic [7:0]  bf [4];
    tok_t        res [6];
    int          rn;

    tok_t        tokens_due [$];
    logic [7:0]  src_q [$];
    logic        eof_q [$];
    int          errors = 0;
    int          burst_left = 0;

    function automatic logic [7:0] kw_byte_at(int k, int unsigned pos);
        logic [7:0] cp;
        cp = kw_cp[k][pos / 3];
        case (pos % 3)
            0: return UTF_LEAD;
            1: return (cp >= 8'h40) ? UTF_HIGH : UTF_LOW;
            default: return 8'h80 | (cp & 8'h3F);
        endcase
    endfunction

    function automatic int unsigned sat(int unsigned v);
        return (v >= CNT_MAX) ? CNT_MAX : v + 1;
    endfunction

    function automatic bit is_dig(int c);
        return c >= 48 && c <= 57;
    endfunction

    function automatic bit is_alp(int c);
        return (c >= 65 && c <= 90) || (c >= 97 && c <= 122);
    endfunction

    function automatic void lex_reset();
        ln = 1; cl = 1; md = MD_IDLE; la_n = 0;
        tsl = 1; tsc = 1; tlen = 0; vacc = 0; kwc = '1; kpos = 0;
    endfunction

    function automatic void emit(logic [4:0] t, logic [1:0] e, int unsigned sl,
                                 int unsigned sc, int unsigned len, int unsigned val);
        if (rn < 6) begin
            res[rn] = '{t, e, sl[15:0], sc[15:0], len[15:0], val, 1'b0};
            rn++;
        end
    endfunction

    function automatic void mv(logic [7:0] b);
        if (b == CH_LF) begin
            ln = sat(ln);
            cl = 1;
        end
        else cl = sat(cl);
    endfunction

    function automatic void take(logic [7:0] b);
        mv(b);
        tlen = sat(tlen);
    endfunction

    function automatic void begin_tok();
        tsl = ln; tsc = cl; tlen = 0; vacc = 0; kwc = '1; kpos = 0;
    endfunction

    function automatic void add_digit(int unsigned d);
        longint unsigned v;
        v = longint'(vacc) * 10 + d;
        vacc = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
    endfunction

    function automatic void ident_byte(logic [7:0] b);
        for (int k = 0; k < 9; k++)
            if (kwc[k] && (kpos >= 3 * kw_len[k] || kw_byte_at(k, kpos) != b))
                kwc[k] = 1'b0;
        if (kpos < 31) kpos++;
        take(b);
    endfunction

    function automatic void finish_tok();
        logic [4:0] t;
        t = T_IDENT;
        case (md)
            MD_IDENT: begin
                for (int k = 0; k < 9; k++)
                    if (kwc[k] && 3 * kw_len[k] == kpos) t = 5'(k + 1);
                emit(t, ERR_NONE, tsl, tsc, tlen, 0);
            end
            MD_NUM, MD_BNUM: emit(T_INT, ERR_NONE, tsl, tsc, tlen, vacc);
            MD_NUMFRAC, MD_BFRAC: emit(T_FLOAT, ERR_NONE, tsl, tsc, tlen, vacc);
            MD_STR: emit(T_UNKNOWN, ERR_UNTERM, tsl, tsc, tlen, 0);
            default: ;
        endcase
        md = MD_IDLE;
    endfunction

    // Byte at offset k from base: its value, -1 if not yet here, -2 if past the end.
    function automatic int peek(int base, int avail, int k, bit eof);
        if (k < avail) return bf[base + k];
        return eof ? -2 : -1;
    endfunction

    function automatic int beng(int base, int avail, bit eof);
        if (avail >= 1 && bf[base] != UTF_LEAD) return 0;
        if (avail >= 2 && bf[base + 1] != UTF_HIGH) return 0;
        if (avail >= 3) return (bf[base + 2] >= BDIG_ZERO && bf[base + 2] <= BDIG_NINE);
        return eof ? 0 : -1;
    endfunction

    function automatic void lex_byte(logic [7:0] nb, bit eof);
        int n, i, avail, q, bb, c;
        bit hold, frac;
        logic [4:0] one, two;
        n = 0; i = 0; hold = 0; rn = 0;
        for (int k = 0; k < la_n; k++) begin
            bf[n] = la[k];
            n++;
        end
        bf[n] = nb;
        n++;
        while (i < n && !hold) begin
            c = bf[i];
            avail = n - i;
            case (md)
                MD_IDLE: begin
                    if (c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF) begin
                        mv(c); i++;
                    end
                    else if (c == CH_SLASH) begin
                        q = peek(i, avail, 1, eof);
                        if (q == -1) hold = 1;
                        else if (q == CH_SLASH) begin
                            mv(c); mv(c); i += 2; md = MD_COMMENT;
                        end
                        else begin
                            emit(T_SLASH, ERR_NONE, ln, cl, 1, 0); mv(c); i++;
                        end
                    end
                    else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR ||
                             c == CH_LPAREN || c == CH_RPAREN || c == CH_SEMI) begin
                        one = (c == CH_PLUS) ? T_PLUS : (c == CH_MINUS) ? T_MINUS :
                              (c == CH_STAR) ? T_STAR : (c == CH_LPAREN) ? T_LPAREN :
                              (c == CH_RPAREN) ? T_RPAREN : T_SEMI;
                        emit(one, ERR_NONE, ln, cl, 1, 0); mv(c); i++;
                    end
                    else if (c == CH_EQ || c == CH_BANG || c == CH_LT || c == CH_GT) begin
                        q = peek(i, avail, 1, eof);
                        if (q == -1) hold = 1;
                        else begin
                            one = (c == CH_EQ) ? T_ASSIGN : (c == CH_BANG) ? T_UNKNOWN :
                                  (c == CH_LT) ? T_LT : T_GT;
                            two = (c == CH_EQ) ? T_EQ : (c == CH_BANG) ? T_NE :
                                  (c == CH_LT) ? T_LE : T_GE;
                            if (q == CH_EQ) begin
                                emit(two, ERR_NONE, ln, cl, 2, 0);
                                mv(c); mv(CH_EQ); i += 2;
                            end
                            else begin
                                emit(one, (c == CH_BANG) ? ERR_BANG : ERR_NONE, ln, cl, 1, 0);
                                mv(c); i++;
                            end
                        end
                    end
                    else if (is_dig(c)) begin
                        begin_tok(); add_digit(c - 48); take(c); i++; md = MD_NUM;
                    end
                    else if (c == UTF_LEAD && (bb = beng(i, avail, eof)) != 0) begin
                        if (bb < 0) hold = 1;
                        else begin
                            begin_tok(); add_digit(bf[i + 2] - BDIG_ZERO);
                            take(bf[i]); take(bf[i + 1]); take(bf[i + 2]);
                            i += 3; md = MD_BNUM;
                        end
                    end
                    else if (c == CH_QUOTE) begin
                        begin_tok(); take(c); i++; md = MD_STR;
                    end
                    else if (is_alp(c) || c == CH_UNDER || c >= 128) begin
                        begin_tok(); ident_byte(c); i++; md = MD_IDENT;
                    end
                    else begin
                        emit(T_UNKNOWN, ERR_UNKNOWN, ln, cl, 1, 0); mv(c); i++;
                    end
                end
                MD_IDENT: begin
                    if (is_alp(c) || is_dig(c) || c == CH_UNDER || c >= 128) begin
                        ident_byte(c); i++;
                    end
                    else finish_tok();
                end
                MD_NUM: begin
                    if (is_dig(c)) begin
                        add_digit(c - 48); take(c); i++;
                    end
                    else if (c == CH_DOT) begin
                        q = peek(i, avail, 1, eof);
                        if (q == -1) hold = 1;
                        else if (q >= 0 && is_dig(q)) begin
                            take(c); i++; md = MD_NUMFRAC;
                        end
                        else finish_tok();
                    end
                    else finish_tok();
                end
                MD_NUMFRAC: begin
                    if (is_dig(c)) begin
                        take(c); i++;
                    end
                    else finish_tok();
                end
                MD_BNUM: begin
                    if (c == UTF_LEAD) begin
                        bb = beng(i, avail, eof);
                        if (bb < 0) hold = 1;
                        else if (bb == 1) begin
                            add_digit(bf[i + 2] - BDIG_ZERO);
                            take(bf[i]); take(bf[i + 1]); take(bf[i + 2]); i += 3;
                        end
                        else finish_tok();
                    end
                    else if (c == CH_DOT) begin
                        frac = 0;
                        q = peek(i, avail, 1, eof);
                        if (q == -1) hold = 1;
                        else if (q >= 0 && is_dig(q)) frac = 1;
                        else if (q == UTF_LEAD) begin
                            bb = beng(i + 1, avail - 1, eof);
                            if (bb < 0) hold = 1;
                            else frac = (bb == 1);
                        end
                        if (!hold) begin
                            if (frac) begin
                                take(c); i++; md = MD_BFRAC;
                            end
                            else finish_tok();
                        end
                    end
                    else finish_tok();
                end
                MD_BFRAC: begin
                    if (c == UTF_LEAD) begin
                        bb = beng(i, avail, eof);
                        if (bb < 0) hold = 1;
                        else if (bb == 1) begin
                            take(bf[i]); take(bf[i + 1]); take(bf[i + 2]); i += 3;
                        end
                        else finish_tok();
                    end
                    else if (is_dig(c)) begin
                        take(c); i++;
                    end
                    else finish_tok();
                end
                MD_STR: begin
                    if (c == CH_QUOTE) begin
                        take(c); i++;
                        emit(T_STR, ERR_NONE, tsl, tsc, tlen, 0);
                        md = MD_IDLE;
                    end
                    else if (c == CH_LF) finish_tok();
                    else begin
                        take(c); i++;
                    end
                end
                MD_COMMENT: begin
                    if (c == CH_LF) md = MD_IDLE;
                    else begin
                        mv(c); i++;
                    end
                end
                default: md = MD_IDLE;
            endcase
        end
        la_n = 0;
        if (hold)
            while (i < n && la_n < 3) begin
                la[la_n] = bf[i];
                la_n++; i++;
            end
        if (eof) begin
            finish_tok();
            emit(T_END, ERR_NONE, ln, cl, 0, 0);
            lex_reset();
        end
        if (rn > 0) res[rn - 1].lst = 1'b1;
    endfunction

    task automatic send_byte(logic [7:0] b, logic eof, bit typed, tok_t want);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
            if (gap > 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_byte <= b;
        end_of_input <= eof;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        burst_left--;
        lex_byte(b, eof);
        if (typed) tokens_due.push_back(want);
        else for (int k = 0; k < rn; k++) tokens_due.push_back(res[k]);
    endtask

    function automatic void add_src(logic [7:0] b);
        src_q.push_back(b);
        eof_q.push_back(1'b0);
    endfunction

    function automatic void add_lexeme();
        int kind, len, k;
        kind = $urandom_range(0, 11);
        case (kind)
            0: begin
                len = $urandom_range(1, 6);
                for (int j = 0; j < len; j++)
                    case ($urandom_range(0, 3))
                        0: add_src(8'h61 + $urandom_range(0, 25));
                        1: add_src(8'h41 + $urandom_range(0, 25));
                        2: add_src((j == 0) ? CH_UNDER : 8'h30 + $urandom_range(0, 9));
                        default: add_src($urandom_range(128, 255));
                    endcase
            end
            1, 2: begin
                k = $urandom_range(0, 8);
                len = 3 * kw_len[k];
                case ($urandom_range(0, 5))
                    0: len = len - $urandom_range(1, 2);
                    default: ;
                endcase
                for (int j = 0; j < len; j++) add_src(kw_byte_at(k, j));
                if ($urandom_range(0, 5) == 0) add_src(8'h61 + $urandom_range(0, 25));
            end
            3: begin
                len = ($urandom_range(0, 5) == 0) ? $urandom_range(10, 12) : $urandom_range(1, 4);
                for (int j = 0; j < len; j++) add_src(8'h30 + $urandom_range(0, 9));
                if ($urandom_range(0, 2) == 0) begin
                    add_src(CH_DOT);
                    len = $urandom_range(0, 3);
                    for (int j = 0; j < len; j++) add_src(8'h30 + $urandom_range(0, 9));
                end
            end
            4: begin
                len = $urandom_range(1, 3);
                for (int j = 0; j < len; j++) begin
                    add_src(UTF_LEAD); add_src(UTF_HIGH);
                    add_src(BDIG_ZERO + $urandom_range(0, 9));
                end
                if ($urandom_range(0, 1) == 0) begin
                    add_src(CH_DOT);
                    len = $urandom_range(0, 2);
                    for (int j = 0; j < len; j++)
                        if ($urandom_range(0, 1) == 0) add_src(8'h30 + $urandom_range(0, 9));
                        else begin
                            add_src(UTF_LEAD); add_src(UTF_HIGH);
                            add_src($urandom_range(8'hA0, 8'hB2));
                        end
                end
            end
            5: begin
                add_src(CH_QUOTE);
                len = $urandom_range(0, 5);
                for (int j = 0; j < len; j++) add_src($urandom_range(8'h23, 8'h7E));
                add_src(($urandom_range(0, 3) == 0) ? CH_LF : CH_QUOTE);
            end
            6, 7: begin
                case ($urandom_range(0, 10))
                    0: add_src(CH_PLUS);
                    1: add_src(CH_MINUS);
                    2: add_src(CH_STAR);
                    3: add_src(CH_SLASH);
                    4: add_src(CH_LPAREN);
                    5: add_src(CH_RPAREN);
                    6: add_src(CH_SEMI);
                    7: add_src(CH_EQ);
                    8: add_src(CH_LT);
                    9: add_src(CH_GT);
                    default: add_src(CH_BANG);
                endcase
                if ($urandom_range(0, 1) == 0) add_src(CH_EQ);
            end
            8: begin
                add_src(CH_SLASH); add_src(CH_SLASH);
                len = $urandom_range(0, 4);
                for (int j = 0; j < len; j++) add_src($urandom_range(8'h20, 8'hFF));
                add_src(CH_LF);
            end
            9: add_src($urandom_range(0, 255));
            default: begin
                case ($urandom_range(0, 3))
                    0: add_src(CH_SPACE);
                    1: add_src(CH_TAB);
                    2: add_src(CH_CR);
                    default: add_src(CH_LF);
                endcase
            end
        endcase
        if ($urandom_range(0, 1) == 0) add_src(CH_SPACE);
        if ($urandom_range(0, 14) == 0) eof_q[eof_q.size() - 1] = 1'b1;
    endfunction

    stim_row_t dir_tab [24];

    initial begin
        dir_tab = '{
            '{CH_PLUS, 1'b0, 1'b1, '{T_PLUS, ERR_NONE, 16'd1, 16'd1, 16'd1, 32'd0, 1'b1}},
            '{8'h2C, 1'b0, 1'b1, '{T_UNKNOWN, ERR_UNKNOWN, 16'd1, 16'd2, 16'd1, 32'd0, 1'b1}},
            '{CH_BANG, 1'b0, 1'b0, '0},
            '{8'h78, 1'b0, 1'b1, '{T_UNKNOWN, ERR_BANG, 16'd1, 16'd3, 16'd1, 32'd0, 1'b1}},
            '{CH_LF, 1'b0, 1'b0, '0},
            '{CH_QUOTE, 1'b0, 1'b0, '0},
            '{8'h61, 1'b0, 1'b0, '0},
            '{CH_LF, 1'b0, 1'b0, '0},
            '{CH_LT, 1'b0, 1'b0, '0},
            '{CH_EQ, 1'b0, 1'b0, '0},
            '{CH_GT, 1'b0, 1'b0, '0},
            '{8'h71, 1'b0, 1'b0, '0},
            '{CH_SLASH, 1'b0, 1'b0, '0},
            '{CH_SLASH, 1'b0, 1'b0, '0},
            '{8'h7A, 1'b0, 1'b0, '0},
            '{CH_LF, 1'b0, 1'b0, '0},
            '{UTF_LEAD, 1'b0, 1'b0, '0},
            '{UTF_HIGH, 1'b0, 1'b0, '0},
            '{BDIG_NINE, 1'b0, 1'b0, '0},
            '{CH_DOT, 1'b0, 1'b0, '0},
            '{8'h35, 1'b0, 1'b0, '0},
            '{CH_SEMI, 1'b0, 1'b0, '0},
            '{8'hFF, 1'b0, 1'b0, '0},
            '{8'h00, 1'b1, 1'b0, '0}};
        lex_reset();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        foreach (dir_tab[r])
            send_byte(dir_tab[r].b, dir_tab[r].eof, dir_tab[r].typed, dir_tab[r].want);
        while (src_q.size() < 120) add_lexeme();
        eof_q[eof_q.size() - 1] = 1'b1;
        foreach (src_q[r]) send_byte(src_q[r], eof_q[r], 1'b0, '0);
        in_valid <= 1'b0;
        while (tokens_due.size() != 0) @(posedge clk);
        repeat (30) @(posedge clk);
        if (errors == 0) $display("[ OK ] regression clean");
        else $display("[FAIL] regression broken");
        $finish;
    end

    int stall_mode = 0;
    int stall_cnt = 0;

    always @(posedge clk) begin
        stall_cnt <= stall_cnt + 1;
        if (stall_cnt % 80 == 79) stall_mode <= $urandom_range(0, 2);
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 3) != 0);
        endcase
    end

    tok_t got, exp_tok;

    always @(posedge clk) begin
        if (rst_n && out_valid && !out_stall) begin
            got = '{token_type, error_code, start_line, start_col, byte_length, int_value, last};
            if (tokens_due.size() == 0) begin
                $display("%0t: unexpected token, actual %p", $time, got);
                errors++;
            end
            else begin
                exp_tok = tokens_due.pop_front();
                if (got.tt !== exp_tok.tt)
                    $display("%0t: token_type expected %0d actual %0d", $time, exp_tok.tt, got.tt);
                if (got.ec !== exp_tok.ec)
                    $display("%0t: error_code expected %0d actual %0d", $time, exp_tok.ec, got.ec);
                if (got.sl !== exp_tok.sl)
                    $display("%0t: start_line expected %0d actual %0d", $time, exp_tok.sl, got.sl);
                if (got.sc !== exp_tok.sc)
                    $display("%0t: start_col expected %0d actual %0d", $time, exp_tok.sc, got.sc);
                if (got.bl !== exp_tok.bl)
                    $display("%0t: byte_length expected %0d actual %0d", $time, exp_tok.bl, got.bl);
                if (got.iv !== exp_tok.iv)
                    $display("%0t: int_value expected %0d actual %0d", $time, exp_tok.iv, got.iv);
                if (got.lst !== exp_tok.lst)
                    $display("%0t: last expected %0d actual %0d", $time, exp_tok.lst, got.lst);
                if (got !== exp_tok) errors++;
            end
        end
    end

    int idle_cycles = 0;

    always @(posedge clk) begin
        if (rst_n) begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
            else idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

/* files.f */
sv/ust_pkg.sv
sv/ust_front.sv
sv/ust_engine.sv
sv/utf8_source_tokenizer.sv
tb/utf8_source_tokenizer_tb.sv
